// ===== rtl/sliding_window_median_filter_unit_assert.svh =====
// Assertion macros shared by the median filter RTL.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWMF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWMF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/swmf_pkg.sv =====
// Shared constants and types for the sliding window median filter.
`timescale 1ns / 1ps
`default_nettype none

package swmf_pkg;

  localparam int unsigned WindowDefault     = 8;
  localparam int unsigned SampleBitsDefault = 16;

  // Flags that one cell of the sorted chain shows to its neighbors.
  typedef struct packed {
    logic vld;    // cell holds a sample for this request
    logic le;     // cell value is less than or equal to the new sample
    logic shift;  // cell sits at or above the evicted sample
  } cell_flags_t;

endpackage

`default_nettype wire

// ===== rtl/swmf_ifs.sv =====
// Valid/ready channel interfaces for samples and median results.
`timescale 1ns / 1ps
`default_nettype none

interface swmf_sample_if #(
  parameter int unsigned SampleBits = swmf_pkg::SampleBitsDefault
);
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] distance;
  logic                  clear_window;

  modport source (output valid, output distance, output clear_window, input ready);
  modport sink   (input valid, input distance, input clear_window, output ready);
endinterface

interface swmf_result_if #(
  parameter int unsigned SampleBits = swmf_pkg::SampleBitsDefault
);
  logic                valid;
  logic                ready;
  logic [SampleBits:0] median_half;
  logic                median_valid;

  modport source (output valid, output median_half, output median_valid, input ready);
  modport sink   (input valid, input median_half, input median_valid, output ready);
endinterface

`default_nettype wire

// ===== rtl/swmf_cell.sv =====
// One cell of the sorted sample chain: drops the oldest sample and inserts the new one.
`timescale 1ns / 1ps
`default_nettype none

module swmf_cell #(
  parameter int unsigned SampleBits = swmf_pkg::SampleBitsDefault
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        en_i,
  input  wire                        clear_i,
  input  wire                        full_i,
  input  wire  [SampleBits-1:0]      sample_i,
  input  wire  [SampleBits-1:0]      oldest_i,
  input  wire swmf_pkg::cell_flags_t left_flags_i,
  input  wire  [SampleBits-1:0]      left_val_i,
  input  wire swmf_pkg::cell_flags_t right_flags_i,
  input  wire  [SampleBits-1:0]      right_val_i,
  output swmf_pkg::cell_flags_t      flags_o,
  output logic [SampleBits-1:0]      val_o,
  output logic [SampleBits-1:0]      next_val_o,
  output logic                       vld_o
);

  logic                  vld_q, vld_d;
  logic [SampleBits-1:0] val_q, val_d;
  logic                  vld_eff;
  logic                  le;
  logic                  shift;
  logic [SampleBits-1:0] r_val, l_val;
  logic                  r_vld, r_le, l_vld, l_le;

  // A clearing request empties the whole chain before the new sample goes in.
  assign vld_eff = vld_q & ~clear_i;
  assign le      = vld_eff && (val_q <= sample_i);
  // Equal values are interchangeable, so the first copy of the oldest value is removed.
  assign shift   = full_i && vld_eff && (val_q >= oldest_i);

  assign flags_o = '{vld: vld_eff, le: le, shift: shift};
  assign val_o   = val_q;
  assign vld_o   = vld_q;

  // Content of this slot and the one below after the oldest sample is taken out.
  always_comb begin
    r_val = shift ? right_val_i : val_q;
    r_vld = shift ? right_flags_i.vld : vld_eff;
    r_le  = shift ? right_flags_i.le : le;
    l_val = left_flags_i.shift ? val_q : left_val_i;
    l_vld = left_flags_i.shift ? vld_eff : left_flags_i.vld;
    l_le  = left_flags_i.shift ? le : left_flags_i.le;
  end

  always_comb begin
    priority if (r_le) begin
      val_d = r_val;
      vld_d = r_vld;
    end else if (l_le) begin
      val_d = sample_i;
      vld_d = 1'b1;
    end else begin
      val_d = l_val;
      vld_d = l_vld;
    end
  end

  assign next_val_o = val_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sliding_window_median_filter_unit.sv =====
// Top level of the sliding window median filter built on a sorted chain of cells.
//
//   channel    dir  payload                        accepted when
//   sample_i   in   distance, clear_window         valid && ready
//   result_o   out  median_half, median_valid      valid && ready
//
// Each request's result is registered at the edge that takes it and offered in the next cycle.
// A new request is taken while a result waits only if that result leaves the same cycle.
// The chain of Window cells is re-sorted combinationally for each request taken; the two middle cells feed the adder.
// Reset empties the chain and the fill count; no clearing pass is needed.
// A stalled result holds the output register and stops new requests.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_median_filter_unit_assert.svh"

module sliding_window_median_filter_unit #(
  parameter int unsigned Window     = swmf_pkg::WindowDefault,
  parameter int unsigned SampleBits = swmf_pkg::SampleBitsDefault
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  swmf_sample_if.sink     sample_i,
  swmf_result_if.source   result_o
);

  localparam int unsigned FillBits = $clog2(Window + 1);
  localparam int unsigned MidLo    = Window / 2 - 1;
  localparam int unsigned MidHi    = Window / 2;

  logic                  accept;
  logic                  full_now;
  logic [FillBits-1:0]   fill_q, fill_d;
  logic                  out_valid_q;
  logic [SampleBits:0]   median_half_q;
  logic                  median_valid_q;
  logic [SampleBits-1:0] hist_q [Window];
  logic [Window-1:0]     cell_vld;

  swmf_pkg::cell_flags_t flags    [Window];
  logic [SampleBits-1:0] vals     [Window];
  logic [SampleBits-1:0] next_vals[Window];

  assign sample_i.ready = !out_valid_q || result_o.ready;
  assign accept         = sample_i.valid && sample_i.ready;

  assign full_now = !sample_i.clear_window && (fill_q == FillBits'(Window));

  always_comb begin
    priority if (sample_i.clear_window) begin
      fill_d = FillBits'(1);
    end else if (fill_q == FillBits'(Window)) begin
      fill_d = fill_q;
    end else begin
      fill_d = fill_q + FillBits'(1);
    end
  end

  // Arrival-order line: the last tap is the sample that leaves the window next.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist_q[0] <= sample_i.distance;
      for (int unsigned j = 1; j < Window; j++) begin
        hist_q[j] <= hist_q[j-1];
      end
    end
  end

  for (genvar i = 0; i < Window; i++) begin : g_cell
    swmf_pkg::cell_flags_t left_flags, right_flags;
    logic [SampleBits-1:0] left_val, right_val;

    if (i == 0) begin : g_bottom
      // The slot below the chain behaves as a smaller value, so insertion can start here.
      assign left_flags = '{vld: 1'b1, le: 1'b1, shift: 1'b0};
      assign left_val   = '0;
    end else begin : g_inner_l
      assign left_flags = flags[i-1];
      assign left_val   = vals[i-1];
    end

    if (i == Window - 1) begin : g_top
      assign right_flags = '{vld: 1'b0, le: 1'b0, shift: 1'b0};
      assign right_val   = '0;
    end else begin : g_inner_r
      assign right_flags = flags[i+1];
      assign right_val   = vals[i+1];
    end

    swmf_cell #(
      .SampleBits (SampleBits)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (accept),
      .clear_i       (sample_i.clear_window),
      .full_i        (full_now),
      .sample_i      (sample_i.distance),
      .oldest_i      (hist_q[Window-1]),
      .left_flags_i  (left_flags),
      .left_val_i    (left_val),
      .right_flags_i (right_flags),
      .right_val_i   (right_val),
      .flags_o       (flags[i]),
      .val_o         (vals[i]),
      .next_val_o    (next_vals[i]),
      .vld_o         (cell_vld[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      median_valid_q <= (fill_d == FillBits'(Window));
      if (fill_d == FillBits'(Window)) begin
        median_half_q <= {1'b0, next_vals[MidLo]} + {1'b0, next_vals[MidHi]};
      end else begin
        median_half_q <= '0;
      end
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.median_half  = median_half_q;
  assign result_o.median_valid = median_valid_q;

  `SWMF_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= FillBits'(Window), "fill count overran the window")
  `SWMF_ASSERT_IMP(a_cells_match_fill, clk_i, rst_ni, 1'b1, $countones(cell_vld) == int'(fill_q), "occupied cells differ from fill count")
  `SWMF_ASSERT_NXT(a_clear_restart, clk_i, rst_ni, accept && sample_i.clear_window, fill_q == FillBits'(1), "clearing request did not restart the window")
  `SWMF_ASSERT_IMP(a_flag_matches_fill, clk_i, rst_ni, out_valid_q, median_valid_q == (fill_q == FillBits'(Window)), "median flag disagrees with fill count")
  `SWMF_ASSERT_IMP(a_partial_zero, clk_i, rst_ni, out_valid_q && !median_valid_q, median_half_q == '0, "median not zero while window fills")

endmodule

`default_nettype wire
